// ===== hdl/smws_pkg.sv =====
package smws_pkg;

	// Fixed payload widths.
	localparam int unsigned WORD_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_FIRST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_BITS = 2'd2;

	// Reset value of the word length register.
	localparam logic [4:0] WORD_BITS_RESET = 5'd8;

	// Configuration as seen by the shift engine.
	typedef struct packed {
		logic [1:0] clock_mode;
		logic       low_first;
		logic [4:0] word_bits;
	} cfg_t;

	// One classified half-bit tick.
	typedef struct packed {
		logic              offer;
		logic [WORD_W-1:0] word;
		logic              last;
		logic              miso;
	} tick_t;

	// Status of the tick queue.
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

endpackage

// ===== hdl/smws_front.sv =====
module smws_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     cmd,
	input  logic [15:0]              send_word,
	input  logic                     word_is_last,
	input  logic                     miso_level,
	input  logic                     pop,
	output smws_pkg::tick_t          q_item,
	output smws_pkg::q_stat_t        q_stat
);

	smws_pkg::tick_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	smws_pkg::tick_t tick;
	logic            push;
	logic            do_pop;

	// Classify the tick: word fields only matter when a word is offered.
	always_comb begin
		tick.offer = cmd;
		tick.word  = cmd ? send_word : '0;
		tick.last  = cmd & word_is_last;
		tick.miso  = miso_level;
	end

	assign q_stat.full      = (count_q == 2'd2);
	assign q_stat.not_empty = (count_q != 2'd0);
	assign in_stall         = q_stat.full;
	assign push             = in_valid & ~q_stat.full;
	assign do_pop           = pop & q_stat.not_empty;
	assign q_item           = slot_q[rd_ptr_q];

	// Queue payload slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= tick;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/smws_engine.sv =====
module smws_engine #(
	parameter int unsigned MAX_WORD_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  smws_pkg::cfg_t      cfg,
	input  smws_pkg::tick_t     q_item,
	input  logic                q_valid,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                sck_level,
	output logic                mosi_level,
	output logic                ready_res,
	output logic                read_valid,
	output logic [15:0]         received_word,
	output logic                message_done
);

	localparam int unsigned W  = MAX_WORD_BITS;
	localparam int unsigned CW = $clog2(W + 1);
	localparam int unsigned IW = $clog2(W);
	localparam logic [5:0] MAXW6 = 6'(W);

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_FIRST  = 3'b010,
		PH_SECOND = 3'b100
	} phase_t;

	phase_t          ph_q, ph_n;
	logic [W-1:0]    tx_q, tx_n;
	logic [W-1:0]    rx_q, rx_n;
	logic [CW-1:0]   bl_q, bl_n;
	logic            sp_q, sp_n;
	logic            lp_q, lp_n;
	logic            mosi_q, mosi_n;
	logic            out_valid_q;

	logic [5:0]      wb6;
	logic [5:0]      n6;
	logic [CW-1:0]   n;
	logic [CW-1:0]   nm1_full;
	logic [IW-1:0]   nm1;
	logic [W-1:0]    mask;
	logic            cpol;
	logic            sck_first;
	logic            sck;
	logic            valid;
	logic [W-1:0]    rword;
	logic            done;

	// Effective word length: zero counts as one, large values saturate.
	always_comb begin
		wb6 = {1'b0, cfg.word_bits};
		if (wb6 == 6'd0) begin
			n6 = 6'd1;
		end else if (wb6 > MAXW6) begin
			n6 = MAXW6;
		end else begin
			n6 = wb6;
		end
	end

	assign n         = n6[CW-1:0];
	assign nm1_full  = n - CW'(1);
	assign nm1       = nm1_full[IW-1:0];
	assign mask      = {W{1'b1}} >> (CW'(W) - n);
	assign cpol      = cfg.clock_mode[1];
	assign sck_first = cfg.clock_mode[1] ^ cfg.clock_mode[0];

	// One tick per transaction as long as the output register can move.
	assign pop       = q_valid & (~out_valid_q | ~out_stall);
	assign out_valid = out_valid_q;

	// Next state for one half-bit tick.
	always_comb begin
		tx_n   = tx_q;
		rx_n   = rx_q;
		bl_n   = bl_q;
		sp_n   = sp_q;
		lp_n   = lp_q;
		mosi_n = mosi_q;
		ph_n   = ph_q;
		valid  = 1'b0;
		rword  = '0;
		done   = 1'b0;
		sck    = cpol;

		// Take in the MISO level that answers the previous sampling half.
		if (sp_q) begin
			sp_n = 1'b0;
			if (cfg.low_first) begin
				rx_n = (rx_q >> 1) | (W'(q_item.miso) << nm1);
			end else begin
				rx_n = (rx_q << 1) | W'(q_item.miso);
			end
			rx_n = rx_n & mask;
			if (bl_q == '0) begin
				valid = 1'b1;
				rword = rx_n;
				done  = lp_q;
				lp_n  = 1'b0;
			end
		end

		// An idle engine takes an offered word.
		if (ph_q != PH_FIRST && ph_q != PH_SECOND) begin
			ph_n = PH_IDLE;
			if (q_item.offer) begin
				tx_n = W'(q_item.word) & mask;
				rx_n = '0;
				bl_n = n;
				lp_n = q_item.last;
				ph_n = PH_FIRST;
			end
		end

		// Drive the pins for this half-bit.
		case (ph_n)
			PH_FIRST: begin
				if (cfg.low_first) begin
					mosi_n = tx_n[0];
					tx_n   = tx_n >> 1;
				end else begin
					mosi_n = tx_n[nm1];
					tx_n   = (tx_n << 1) & mask;
				end
				sck  = sck_first;
				ph_n = PH_SECOND;
			end
			PH_SECOND: begin
				sck  = ~sck_first;
				sp_n = 1'b1;
				if (bl_n != '0) begin
					bl_n = bl_n - CW'(1);
				end
				ph_n = (bl_n == '0) ? PH_IDLE : PH_FIRST;
			end
			default: begin
				sck = cpol;
			end
		endcase
	end

	// Shift state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			tx_q   <= '0;
			rx_q   <= '0;
			bl_q   <= '0;
			sp_q   <= 1'b0;
			lp_q   <= 1'b0;
			mosi_q <= 1'b0;
		end else if (pop) begin
			ph_q   <= ph_n;
			tx_q   <= tx_n;
			rx_q   <= rx_n;
			bl_q   <= bl_n;
			sp_q   <= sp_n;
			lp_q   <= lp_n;
			mosi_q <= mosi_n;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			sck_level     <= sck;
			mosi_level    <= mosi_n;
			ready_res     <= (ph_n == PH_IDLE);
			read_valid    <= valid;
			received_word <= 16'(rword);
			message_done  <= done;
		end
	end

endmodule

// ===== hdl/spi_master_word_shifter.sv =====
// SPI master word shifter. Each input transaction is one half-bit tick and
// produces exactly one output transaction with the SCK and MOSI levels for
// that half-bit, the ready flag and, on the tick that follows a word's final
// half-bit, the received word and the message-done flag. The block sustains
// one tick per clock cycle while out_stall stays low; a tick's result passes
// through the two-entry tick queue and then the output register. The queue
// lets the input side take up to two more ticks while a result waits to be
// taken. The user must write clock mode, bit order and word length through
// the configuration port only while no tick is in flight; the block itself
// does not enforce this.
module spi_master_word_shifter #(
	parameter int unsigned MAX_WORD_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [15:0] send_word,
	input  logic        word_is_last,
	input  logic        miso_level,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        sck_level,
	output logic        mosi_level,
	output logic        ready_res,
	output logic        read_valid,
	output logic [15:0] received_word,
	output logic        message_done
);

	smws_pkg::cfg_t    cfg_q;
	smws_pkg::tick_t   q_item;
	smws_pkg::q_stat_t q_stat;
	logic              pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_mode <= 2'd0;
			cfg_q.low_first  <= 1'b0;
			cfg_q.word_bits  <= smws_pkg::WORD_BITS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				smws_pkg::REG_CLOCK_MODE: cfg_q.clock_mode <= cfg_data[1:0];
				smws_pkg::REG_LOW_FIRST:  cfg_q.low_first  <= cfg_data[0];
				smws_pkg::REG_WORD_BITS:  cfg_q.word_bits  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	smws_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.send_word    (send_word),
		.word_is_last (word_is_last),
		.miso_level   (miso_level),
		.pop          (pop),
		.q_item       (q_item),
		.q_stat       (q_stat)
	);

	smws_engine #(
		.MAX_WORD_BITS (MAX_WORD_BITS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_item        (q_item),
		.q_valid       (q_stat.not_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.sck_level     (sck_level),
		.mosi_level    (mosi_level),
		.ready_res     (ready_res),
		.read_valid    (read_valid),
		.received_word (received_word),
		.message_done  (message_done)
	);

`ifndef SYNTH
	// A message-done flag only comes with a completed word.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_done |-> read_valid)
		else $error("message_done without read_valid");

	// The received word reads as zero when no word completes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> received_word == 16'd0)
		else $error("received_word not zero without read_valid");

	// A new result only appears after the queue held a tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_stat.not_empty))
		else $error("result without a queued tick");
`endif

endmodule

// ===== sim/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One half-bit of pin levels and word status, as the block reports it.
	typedef struct packed {
		logic                        sck;
		logic                        mosi;
		logic                        ready;
		logic                        rvalid;
		logic [smws_pkg::WORD_W-1:0] rword;
		logic                        done;
	} pin_res_t;

	typedef enum logic [1:0] {SH_IDLE, SH_FIRST, SH_SECOND} shift_ph_t;
	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

	// One line of the directed sequence: either a register write or a tick.
	typedef struct packed {
		row_kind_t                       kind;
		logic [smws_pkg::CFG_IDX_W-1:0]  reg_idx;
		logic [smws_pkg::CFG_DATA_W-1:0] reg_val;
		logic                            cmd;
		logic [smws_pkg::WORD_W-1:0]     word;
		logic                            last;
		logic                            miso;
		logic                            chk;
		pin_res_t                        want;
	} dir_row_t;

	localparam int DIR_N = 25;
	localparam int ITEM_TARGET = 1150;
	localparam int HOLD_CYCLES = 60;

	// Results that can be read straight off the tick sequence.
	localparam pin_res_t NO_PINS = '0;
	localparam pin_res_t PINS_AT_RESET = '{1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0};
	localparam pin_res_t PINS_FIRST_HALF = '{1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0};
	localparam pin_res_t PINS_BUSY_OFFER = '{1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0};
	localparam pin_res_t PINS_WORD_ONE = '{1'b0, 1'b0, 1'b0, 1'b1, 16'h0001, 1'b0};
	localparam pin_res_t PINS_SECOND_HALF = '{1'b1, 1'b0, 1'b1, 1'b0, 16'h0000, 1'b0};
	localparam pin_res_t PINS_MSG_END = '{1'b0, 1'b0, 1'b1, 1'b1, 16'h0000, 1'b1};

	// Word length zero, a one-bit exchange with a busy offer and a back-to-back
	// word, then a saturated length with a mode and length change mid-word.
	dir_row_t dir_tab [0:DIR_N-1] = '{
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1,
			PINS_AT_RESET},
		'{ROW_CFG, smws_pkg::REG_WORD_BITS, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1,
			PINS_FIRST_HALF},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1,
			PINS_BUSY_OFFER},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1,
			PINS_WORD_ONE},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b1,
			PINS_SECOND_HALF},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b1,
			PINS_MSG_END},
		'{ROW_CFG, smws_pkg::REG_WORD_BITS, 5'd31, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_PINS},
		'{ROW_CFG, smws_pkg::REG_CLOCK_MODE, 5'd3, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_PINS},
		'{ROW_CFG, smws_pkg::REG_LOW_FIRST, 5'd1, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b1, 16'h8001, 1'b1, 1'b1, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b0,
			NO_PINS},
		'{ROW_CFG, smws_pkg::REG_CLOCK_MODE, 5'd1, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_PINS},
		'{ROW_CFG, smws_pkg::REG_WORD_BITS, 5'd2, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0,
			NO_PINS},
		'{ROW_CFG, smws_pkg::REG_CLOCK_MODE, 5'd2, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b1, 16'h7FFE, 1'b1, 1'b0, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b1, 1'b0,
			NO_PINS},
		'{ROW_TICK, smws_pkg::REG_CLOCK_MODE, 5'd0, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0,
			NO_PINS}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [smws_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [smws_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic cmd;
	logic [smws_pkg::WORD_W-1:0] send_word;
	logic word_is_last;
	logic miso_level;
	logic out_valid;
	logic out_stall;
	logic sck_level;
	logic mosi_level;
	logic ready_res;
	logic read_valid;
	logic [smws_pkg::WORD_W-1:0] received_word;
	logic message_done;

	// Shadow registers and shift engine state of the predictor.
	logic [1:0] sh_mode;
	logic sh_lsb;
	logic [4:0] sh_bits;
	shift_ph_t eng_ph;
	logic [smws_pkg::WORD_W-1:0] tx_sh;
	logic [smws_pkg::WORD_W-1:0] rx_sh;
	logic [4:0] bits_rem;
	logic samp_pend;
	logic last_pend;
	logic mosi_q;

	pin_res_t pending_pins [$];
	logic row_typed;
	pin_res_t row_want;
	bit tx_lazy;
	bit rx_lazy;
	bit rx_hold_req;
	int n_items;
	int errs;

	spi_master_word_shifter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.send_word(send_word),
		.word_is_last(word_is_last),
		.miso_level(miso_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sck_level(sck_level),
		.mosi_level(mosi_level),
		.ready_res(ready_res),
		.read_valid(read_valid),
		.received_word(received_word),
		.message_done(message_done)
	);

	always #6 clk = ~clk;

	// Advances the shift engine by one half-bit tick and returns its pins.
	function automatic pin_res_t spi_engine_step(input logic c,
			input logic [smws_pkg::WORD_W-1:0] w, input logic l, input logic m);
		pin_res_t r;
		int nb;
		logic [smws_pkg::WORD_W-1:0] msk;
		logic sfirst;
		nb = (sh_bits == 5'd0) ? 1 : ((sh_bits > 5'd16) ? 16 : int'(sh_bits));
		msk = 16'hFFFF >> (16 - nb);
		sfirst = sh_mode[1] ^ sh_mode[0];
		r = '0;
		// The sample of the previous half-bit lands first.
		if (samp_pend) begin
			samp_pend = 1'b0;
			if (sh_lsb)
				rx_sh = (rx_sh >> 1) | (16'(m) << (nb - 1));
			else
				rx_sh = (rx_sh << 1) | 16'(m);
			rx_sh &= msk;
			if (bits_rem == 5'd0) begin
				r.rvalid = 1'b1;
				r.rword = rx_sh;
				r.done = last_pend;
				last_pend = 1'b0;
			end
		end
		// A word is taken only while idle; offers during a word are dropped.
		if (eng_ph != SH_FIRST && eng_ph != SH_SECOND) begin
			eng_ph = SH_IDLE;
			if (c) begin
				tx_sh = w & msk;
				rx_sh = '0;
				bits_rem = 5'(nb);
				last_pend = l;
				eng_ph = SH_FIRST;
			end
		end
		case (eng_ph)
			SH_FIRST: begin
				if (sh_lsb) begin
					mosi_q = tx_sh[0];
					tx_sh = tx_sh >> 1;
				end else begin
					mosi_q = tx_sh[nb-1];
					tx_sh = (tx_sh << 1) & msk;
				end
				r.sck = sfirst;
				eng_ph = SH_SECOND;
			end
			SH_SECOND: begin
				r.sck = ~sfirst;
				samp_pend = 1'b1;
				if (bits_rem != 5'd0)
					bits_rem--;
				eng_ph = (bits_rem == 5'd0) ? SH_IDLE : SH_FIRST;
			end
			default: r.sck = sh_mode[1];
		endcase
		r.mosi = mosi_q;
		r.ready = (eng_ph == SH_IDLE);
		return r;
	endfunction

	task automatic log_fail(input string msg);
		errs++;
		if (errs <= 10)
			$display("%s", msg);
	endtask

	// Offers one tick transaction, after a random gap when tx_lazy is set, and waits until it is taken.
	task automatic push_tick(input dir_row_t row, input bit rnd);
		int gap;
		gap = tx_lazy ? $urandom_range(0, 18) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (rnd) begin
			if (eng_ph == SH_IDLE)
				row.cmd = ($urandom_range(0, 4) != 0);
			else
				row.cmd = ($urandom_range(0, 9) == 0);
			row.word = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
			row.last = ($urandom_range(0, 3) == 0);
			row.miso = 1'($urandom_range(0, 1));
			row.chk = 1'b0;
		end
		row_typed = row.chk;
		row_want = row.want;
		in_valid <= 1'b1;
		cmd <= row.cmd;
		send_word <= row.word;
		word_is_last <= row.last;
		miso_level <= row.miso;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_items++;
	endtask

	// Stops offering and lets every outstanding result drain.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [smws_pkg::CFG_IDX_W-1:0] idx,
			input logic [smws_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			smws_pkg::REG_CLOCK_MODE: sh_mode = val[1:0];
			smws_pkg::REG_LOW_FIRST: sh_lsb = val[0];
			smws_pkg::REG_WORD_BITS: sh_bits = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: random or long hold-offs before each output transaction.
	initial begin
		int hold;
		out_stall = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			hold = rx_hold_req ? HOLD_CYCLES : (rx_lazy ? $urandom_range(0, 18) : 0);
			rx_hold_req = 1'b0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Predict on each accepted tick and check each accepted result in order.
	always @(posedge clk) begin
		pin_res_t got;
		pin_res_t want;
		pin_res_t pr;
		if (arst_n) begin
			got = '{sck_level, mosi_level, ready_res, read_valid, received_word, message_done};
			if (out_valid && !out_stall) begin
				if (pending_pins.size() == 0) begin
					log_fail($sformatf("unexpected output transaction %h", got));
				end else begin
					want = pending_pins.pop_front();
					if (got !== want)
						log_fail($sformatf({"mismatch: want sck %b mosi %b ready %b valid %b ",
							"word %h done %b, got sck %b mosi %b ready %b valid %b word %h ",
							"done %b"}, want.sck, want.mosi, want.ready, want.rvalid,
							want.rword, want.done, got.sck, got.mosi, got.ready, got.rvalid,
							got.rword, got.done));
				end
			end
			if (in_valid && !in_stall) begin
				pr = spi_engine_step(cmd, send_word, word_is_last, miso_level);
				pending_pins.push_back(row_typed ? row_want : pr);
			end
		end
	end

	initial begin
		#6_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		dir_row_t blank;
		int phase_no;
		int len;
		logic [4:0] wb;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = 1'b0;
		send_word = '0;
		word_is_last = 1'b0;
		miso_level = 1'b0;
		sh_mode = 2'd0;
		sh_lsb = 1'b0;
		sh_bits = smws_pkg::WORD_BITS_RESET;
		eng_ph = SH_IDLE;
		tx_sh = '0;
		rx_sh = '0;
		bits_rem = '0;
		samp_pend = 1'b0;
		last_pend = 1'b0;
		mosi_q = 1'b0;
		row_typed = 1'b0;
		row_want = '0;
		tx_lazy = 1'b1;
		rx_lazy = 1'b1;
		rx_hold_req = 1'b0;
		n_items = 0;
		errs = 0;
		blank = '0;
		phase_no = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed sequence.
		for (int i = 0; i < DIR_N; i++) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				wait_drained();
				write_cfg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
			end else begin
				push_tick(dir_tab[i], 1'b0);
			end
		end

		// Random phases, each opened with the pipeline drained and a fresh setting.
		while (n_items < ITEM_TARGET) begin
			wait_drained();
			phase_no++;
			if (phase_no == 1)
				wb = 5'd16;
			else if (phase_no == 2)
				wb = 5'd1;
			else if ($urandom_range(0, 9) == 0)
				wb = 5'($urandom_range(0, 31));
			else
				wb = 5'($urandom_range(1, 16));
			if (phase_no <= 2 || $urandom_range(0, 1) == 1)
				write_cfg(smws_pkg::REG_WORD_BITS, wb);
			if ($urandom_range(0, 1) == 1)
				write_cfg(smws_pkg::REG_CLOCK_MODE, 5'($urandom_range(0, 3)));
			if ($urandom_range(0, 1) == 1)
				write_cfg(smws_pkg::REG_LOW_FIRST, 5'($urandom_range(0, 1)));
			tx_lazy = ($urandom_range(0, 2) != 0);
			rx_lazy = ($urandom_range(0, 2) != 0);
			// Periodically let the result side sit still while ticks keep coming.
			if (phase_no % 8 == 1) begin
				rx_hold_req = 1'b1;
				tx_lazy = 1'b0;
			end
			len = $urandom_range(20, 120);
			if (len > ITEM_TARGET - n_items)
				len = ITEM_TARGET - n_items;
			repeat (len) push_tick(blank, 1'b1);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (pending_pins.size() != 0)
			log_fail($sformatf("%0d results never arrived", pending_pins.size()));
		if (errs == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
